### rtl/tsemh_pkg.sv
// Shared types and codes of the three-state efficiency mixture histogram.
// Holds command, status and register codes, payload structs and the
// controller/datapath command and status bundles. Depends on nothing.
package tsemh_pkg;

  // Request command codes
  localparam logic [2:0] CMD_LOAD_EPS = 3'd0;
  localparam logic [2:0] CMD_LOAD_P1  = 3'd1;
  localparam logic [2:0] CMD_LOAD_P2  = 3'd2;
  localparam logic [2:0] CMD_LOAD_P3  = 3'd3;
  localparam logic [2:0] CMD_COMPUTE  = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIME_BINS = 3'd0;
  localparam logic [2:0] CFG_EPS_BINS  = 3'd1;
  localparam logic [2:0] CFG_BRIGHT1   = 3'd2;
  localparam logic [2:0] CFG_BRIGHT2   = 3'd3;
  localparam logic [2:0] CFG_BRIGHT3   = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [14:0] item_index;
    logic [15:0] item_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } rsp_t;

  // Which loop index addresses the efficiency and probability tables
  typedef enum logic [1:0] {
    TS_I,
    TS_J,
    TS_H
  } tsel_e;

  typedef enum logic [4:0] {
    S_INIT_CLR,
    S_IDLE,
    S_READ,
    S_CLR,
    S_RM_RD,
    S_RM_WR,
    S_W,
    S_DEN,
    S_I_RD,
    S_I_CHK,
    S_J_RD,
    S_J_CHK,
    S_H_RD,
    S_H_CHK,
    S_NUM,
    S_BS_RD,
    S_BS_CMP,
    S_ACC_RD,
    S_ACC_WR,
    S_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  host_we;
    logic  host_rd;
    logic  resp_load;
    logic  resp_read;
    logic  resp_cmp;
    logic  resp_bad;
    logic  clr_init;
    logic  clr_step;
    logic  rm_init;
    logic  rm_write;
    logic  k_init;
    logic  w_calc;
    logic  den_calc;
    logic  l_next;
    logic  i_init;
    logic  i_take;
    logic  i_next;
    logic  j_init;
    logic  j_take;
    logic  j_next;
    logic  h_init;
    logic  h_take;
    logic  h_next;
    logic  num_calc;
    logic  bs_cmp;
    logic  addr_calc;
    logic  acc_write;
    tsel_e tsel;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic den_zero;
    logic kl_last;
    logic i_last;
    logic j_last;
    logic h_last;
    logic p1_ok;
    logic p2_ok;
    logic p3_ok;
    logic bs_run;
  } sts_t;

endpackage

### rtl/three_state_eps_mixture_histogram.sv
// Top level of the three-state efficiency mixture histogram.
// Joins the sequencer and the datapath. Depends on tsemh_pkg, tsemh_ctrl, tsemh_dp.
//
// Use: a request (req_i) is taken at a rising edge with start high and busy low.
// Every request gives one result on rsp_o, marked by done_o for one cycle;
// the receiver cannot stall it. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i at a rising edge; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Table loads: result in the cycle after the request, busy stays low, so a
// load can be taken every cycle. Histogram read: busy for one cycle, result
// after the histogram memory read port and then the result register.
// Compute: a clearing pass over the whole histogram memory, a running-maximum
// pass over the efficiency table, then for each split the outer, middle and
// inner bin loops; each accepted term takes a binary search against the
// running-maximum memory and the read-modify-write of the histogram word.
// The result follows the last term. After reset the block runs the same
// clearing pass with busy high; configuration writes are taken then.
module three_state_eps_mixture_histogram #(
  parameter int unsigned MAX_TIME_BINS = 16,
  parameter int unsigned MAX_EPS_BINS  = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tsemh_pkg::req_t req_i,
  output logic            done_o,
  output tsemh_pkg::rsp_t rsp_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);

  tsemh_pkg::ctl_t ctl;
  tsemh_pkg::sts_t sts;

  // Sequencer
  tsemh_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .cmd_i (req_i.cmd),
    .sts_i (sts),
    .busy,
    .ctl_o (ctl)
  );

  // Datapath
  tsemh_dp #(
    .MAX_TIME_BINS(MAX_TIME_BINS),
    .MAX_EPS_BINS (MAX_EPS_BINS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .req_i,
    .ctl_i (ctl),
    .sts_o (sts),
    .done_o,
    .rsp_o
  );

endmodule

### rtl/tsemh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for all tables and the histogram. Depends on nothing.
module tsemh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/tsemh_ctrl.sv
// Sequencer of the mixture histogram: clearing pass, running-maximum build,
// nested split/bin loops, bin search and accumulation. Depends on tsemh_pkg.
module tsemh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [2:0]       cmd_i,
  input  tsemh_pkg::sts_t  sts_i,
  output logic             busy,
  output tsemh_pkg::ctl_t  ctl_o
);

  tsemh_pkg::state_e state_q, state_d;
  logic adv_h, adv_j, adv_i, adv_kl;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsemh_pkg::S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    ctl_o.tsel = tsemh_pkg::TS_I;
    busy = 1'b1;
    adv_h = 1'b0;
    adv_j = 1'b0;
    adv_i = 1'b0;
    adv_kl = 1'b0;
    unique case (state_q)
      tsemh_pkg::S_INIT_CLR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = tsemh_pkg::S_IDLE;
      end
      tsemh_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          priority if (cmd_i == tsemh_pkg::CMD_LOAD_EPS || cmd_i == tsemh_pkg::CMD_LOAD_P1 ||
                       cmd_i == tsemh_pkg::CMD_LOAD_P2 || cmd_i == tsemh_pkg::CMD_LOAD_P3) begin
            ctl_o.host_we = 1'b1;
            ctl_o.resp_load = 1'b1;
          end else if (cmd_i == tsemh_pkg::CMD_READ) begin
            ctl_o.host_rd = 1'b1;
            state_d = tsemh_pkg::S_READ;
          end else if (cmd_i == tsemh_pkg::CMD_COMPUTE) begin
            ctl_o.clr_init = 1'b1;
            state_d = tsemh_pkg::S_CLR;
          end else begin
            ctl_o.resp_bad = 1'b1;
          end
        end
      end
      tsemh_pkg::S_READ: begin
        ctl_o.resp_read = 1'b1;
        state_d = tsemh_pkg::S_IDLE;
      end
      tsemh_pkg::S_CLR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          if (sts_i.empty) begin
            state_d = tsemh_pkg::S_DONE;
          end else begin
            ctl_o.rm_init = 1'b1;
            state_d = tsemh_pkg::S_RM_RD;
          end
        end
      end
      tsemh_pkg::S_RM_RD: state_d = tsemh_pkg::S_RM_WR;
      tsemh_pkg::S_RM_WR: begin
        ctl_o.rm_write = 1'b1;
        if (sts_i.i_last) begin
          ctl_o.k_init = 1'b1;
          state_d = tsemh_pkg::S_W;
        end else begin
          state_d = tsemh_pkg::S_RM_RD;
        end
      end
      tsemh_pkg::S_W: begin
        ctl_o.w_calc = 1'b1;
        state_d = tsemh_pkg::S_DEN;
      end
      tsemh_pkg::S_DEN: begin
        ctl_o.den_calc = 1'b1;
        ctl_o.i_init = 1'b1;
        if (sts_i.den_zero) adv_kl = 1'b1;
        else state_d = tsemh_pkg::S_I_RD;
      end
      tsemh_pkg::S_I_RD: state_d = tsemh_pkg::S_I_CHK;
      tsemh_pkg::S_I_CHK: begin
        if (sts_i.p1_ok) begin
          ctl_o.i_take = 1'b1;
          ctl_o.j_init = 1'b1;
          state_d = tsemh_pkg::S_J_RD;
        end else begin
          adv_i = 1'b1;
        end
      end
      tsemh_pkg::S_J_RD: begin
        ctl_o.tsel = tsemh_pkg::TS_J;
        state_d = tsemh_pkg::S_J_CHK;
      end
      tsemh_pkg::S_J_CHK: begin
        ctl_o.tsel = tsemh_pkg::TS_J;
        if (sts_i.p2_ok) begin
          ctl_o.j_take = 1'b1;
          ctl_o.h_init = 1'b1;
          state_d = tsemh_pkg::S_H_RD;
        end else begin
          adv_j = 1'b1;
        end
      end
      tsemh_pkg::S_H_RD: begin
        ctl_o.tsel = tsemh_pkg::TS_H;
        state_d = tsemh_pkg::S_H_CHK;
      end
      tsemh_pkg::S_H_CHK: begin
        ctl_o.tsel = tsemh_pkg::TS_H;
        if (sts_i.p3_ok) begin
          ctl_o.h_take = 1'b1;
          state_d = tsemh_pkg::S_NUM;
        end else begin
          adv_h = 1'b1;
        end
      end
      tsemh_pkg::S_NUM: begin
        ctl_o.num_calc = 1'b1;
        state_d = tsemh_pkg::S_BS_RD;
      end
      tsemh_pkg::S_BS_RD: begin
        if (sts_i.bs_run) begin
          state_d = tsemh_pkg::S_BS_CMP;
        end else begin
          ctl_o.addr_calc = 1'b1;
          state_d = tsemh_pkg::S_ACC_RD;
        end
      end
      tsemh_pkg::S_BS_CMP: begin
        ctl_o.bs_cmp = 1'b1;
        state_d = tsemh_pkg::S_BS_RD;
      end
      tsemh_pkg::S_ACC_RD: state_d = tsemh_pkg::S_ACC_WR;
      tsemh_pkg::S_ACC_WR: begin
        ctl_o.acc_write = 1'b1;
        adv_h = 1'b1;
      end
      tsemh_pkg::S_DONE: begin
        ctl_o.resp_cmp = 1'b1;
        state_d = tsemh_pkg::S_IDLE;
      end
      default: state_d = tsemh_pkg::S_IDLE;
    endcase

    // Advance the nested loops, carrying into the outer ones
    if (adv_h) begin
      if (!sts_i.h_last) begin
        ctl_o.h_next = 1'b1;
        state_d = tsemh_pkg::S_H_RD;
      end else begin
        adv_j = 1'b1;
      end
    end
    if (adv_j) begin
      if (!sts_i.j_last) begin
        ctl_o.j_next = 1'b1;
        state_d = tsemh_pkg::S_J_RD;
      end else begin
        adv_i = 1'b1;
      end
    end
    if (adv_i) begin
      if (!sts_i.i_last) begin
        ctl_o.i_next = 1'b1;
        state_d = tsemh_pkg::S_I_RD;
      end else begin
        adv_kl = 1'b1;
      end
    end
    if (adv_kl) begin
      if (!sts_i.kl_last) begin
        ctl_o.l_next = 1'b1;
        state_d = tsemh_pkg::S_W;
      end else begin
        state_d = tsemh_pkg::S_DONE;
      end
    end
  end

endmodule

### rtl/tsemh_dp.sv
// Datapath of the mixture histogram: configuration registers, tables,
// histogram memory, loop counters, arithmetic and result register.
// Depends on tsemh_pkg and tsemh_ram.
module tsemh_dp #(
  parameter int unsigned MAX_TIME_BINS = 16,
  parameter int unsigned MAX_EPS_BINS  = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  tsemh_pkg::req_t  req_i,
  input  tsemh_pkg::ctl_t  ctl_i,
  output tsemh_pkg::sts_t  sts_o,
  output logic             done_o,
  output tsemh_pkg::rsp_t  rsp_o
);

  localparam int unsigned EA  = $clog2(MAX_EPS_BINS);
  localparam int unsigned EW  = $clog2(MAX_EPS_BINS + 1);
  localparam int unsigned EW1 = EW + 1;
  localparam int unsigned TW  = $clog2(MAX_TIME_BINS + 1);
  localparam int unsigned KW  = $clog2(MAX_TIME_BINS);
  localparam int unsigned HIST_DEPTH = MAX_TIME_BINS * MAX_TIME_BINS * MAX_EPS_BINS;
  localparam int unsigned HA  = $clog2(HIST_DEPTH);
  localparam int unsigned WW  = 16 + TW;
  localparam int unsigned DW  = WW + 2;
  localparam int unsigned NW  = DW + 16;
  localparam int unsigned RW  = 2 * TW;
  localparam int unsigned PW  = RW + EW;

  // Configuration registers
  logic [4:0]  time_bins_q;
  logic [7:0]  eps_bins_q;
  logic [15:0] bright1_q, bright2_q, bright3_q, thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_bins_q <= 5'd16;
      eps_bins_q  <= 8'd128;
      bright1_q   <= 16'd256;
      bright2_q   <= 16'd256;
      bright3_q   <= 16'd256;
      thr_q       <= 16'd66;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsemh_pkg::CFG_TIME_BINS: time_bins_q <= cfg_data_i[4:0];
        tsemh_pkg::CFG_EPS_BINS:  eps_bins_q  <= cfg_data_i[7:0];
        tsemh_pkg::CFG_BRIGHT1:   bright1_q   <= cfg_data_i;
        tsemh_pkg::CFG_BRIGHT2:   bright2_q   <= cfg_data_i;
        tsemh_pkg::CFG_BRIGHT3:   bright3_q   <= cfg_data_i;
        tsemh_pkg::CFG_THRESHOLD: thr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the bin counts to the built sizes
  logic [TW-1:0] tb_eff;
  logic [EW-1:0] eb_eff;
  assign tb_eff = TW'((32'(time_bins_q) > 32'(MAX_TIME_BINS)) ? 32'(MAX_TIME_BINS)
                                                               : 32'(time_bins_q));
  assign eb_eff = EW'((32'(eps_bins_q) > 32'(MAX_EPS_BINS)) ? 32'(MAX_EPS_BINS)
                                                             : 32'(eps_bins_q));

  // Host request decode
  logic [31:0]   idx32;
  logic          load_ok, read_ok;
  assign idx32   = 32'(req_i.item_index);
  assign load_ok = idx32 < 32'(MAX_EPS_BINS);
  assign read_ok = idx32 < 32'(HIST_DEPTH);

  // Loop counters and search bounds
  logic [KW-1:0] k_q, l_q;
  logic [EA-1:0] i_q, j_q, h_q;
  logic [EW-1:0] lo_q, hi_q, mid, ix;
  logic [HA-1:0] clr_addr_q, acc_addr_q, base_q;
  logic [RW-1:0] row_q;
  logic [TW-1:0] m_cnt;
  logic          l_last, k_last;

  assign mid    = EW'((EW1'(lo_q) + EW1'(hi_q)) >> 1);
  assign ix     = (lo_q < eb_eff) ? lo_q : eb_eff - EW'(1);
  assign m_cnt  = tb_eff - TW'(1) - TW'(k_q) - TW'(l_q);
  assign k_last = TW'(k_q) == tb_eff - TW'(1);
  assign l_last = TW'(l_q) == tb_eff - TW'(1) - TW'(k_q);

  // Table memories
  logic [EA-1:0] tab_addr;
  logic [15:0]   eps_rd, p1_rd, p2_rd, p3_rd, rm_rd, rmax_q, rmax_new;
  logic          we_eps, we_p1, we_p2, we_p3;

  always_comb begin
    unique case (ctl_i.tsel)
      tsemh_pkg::TS_I: tab_addr = i_q;
      tsemh_pkg::TS_J: tab_addr = j_q;
      tsemh_pkg::TS_H: tab_addr = h_q;
      default:         tab_addr = i_q;
    endcase
  end

  assign we_eps = ctl_i.host_we && load_ok && req_i.cmd == tsemh_pkg::CMD_LOAD_EPS;
  assign we_p1  = ctl_i.host_we && load_ok && req_i.cmd == tsemh_pkg::CMD_LOAD_P1;
  assign we_p2  = ctl_i.host_we && load_ok && req_i.cmd == tsemh_pkg::CMD_LOAD_P2;
  assign we_p3  = ctl_i.host_we && load_ok && req_i.cmd == tsemh_pkg::CMD_LOAD_P3;
  assign rmax_new = (eps_rd > rmax_q) ? eps_rd : rmax_q;

  tsemh_ram #(.WIDTH(16), .DEPTH(MAX_EPS_BINS)) u_eps (
    .clk_i, .we_i(we_eps), .waddr_i(idx32[EA-1:0]), .wdata_i(req_i.item_value),
    .raddr_i(tab_addr), .rdata_o(eps_rd)
  );
  tsemh_ram #(.WIDTH(16), .DEPTH(MAX_EPS_BINS)) u_p1 (
    .clk_i, .we_i(we_p1), .waddr_i(idx32[EA-1:0]), .wdata_i(req_i.item_value),
    .raddr_i(tab_addr), .rdata_o(p1_rd)
  );
  tsemh_ram #(.WIDTH(16), .DEPTH(MAX_EPS_BINS)) u_p2 (
    .clk_i, .we_i(we_p2), .waddr_i(idx32[EA-1:0]), .wdata_i(req_i.item_value),
    .raddr_i(tab_addr), .rdata_o(p2_rd)
  );
  tsemh_ram #(.WIDTH(16), .DEPTH(MAX_EPS_BINS)) u_p3 (
    .clk_i, .we_i(we_p3), .waddr_i(idx32[EA-1:0]), .wdata_i(req_i.item_value),
    .raddr_i(tab_addr), .rdata_o(p3_rd)
  );
  // Running maximum of the efficiency table, searched for the bin
  tsemh_ram #(.WIDTH(16), .DEPTH(MAX_EPS_BINS)) u_rmax (
    .clk_i, .we_i(ctl_i.rm_write), .waddr_i(i_q), .wdata_i(rmax_new),
    .raddr_i(mid[EA-1:0]), .rdata_o(rm_rd)
  );

  // Histogram memory
  logic [HA-1:0] h_raddr, h_waddr;
  logic [31:0]   hist_rd, h_wdata;
  logic [32:0]   acc_sum;
  logic [31:0]   add_q;

  assign acc_sum = {1'b0, hist_rd} + {1'b0, add_q};
  assign h_raddr = ctl_i.host_rd ? idx32[HA-1:0] : acc_addr_q;
  assign h_waddr = ctl_i.clr_step ? clr_addr_q : acc_addr_q;
  assign h_wdata = ctl_i.clr_step ? 32'd0 : (acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0]);

  tsemh_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk_i, .we_i(ctl_i.clr_step | ctl_i.acc_write), .waddr_i(h_waddr),
    .wdata_i(h_wdata), .raddr_i(h_raddr), .rdata_o(hist_rd)
  );

  // Control counters
  logic sat_q, rd_ok_q;
  logic bs_le;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      k_q <= '0;
      l_q <= '0;
      i_q <= '0;
      j_q <= '0;
      h_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (ctl_i.clr_init) begin
        clr_addr_q <= '0;
        sat_q <= 1'b0;
      end else if (ctl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + HA'(1);
      end
      if (ctl_i.acc_write && acc_sum[32]) sat_q <= 1'b1;
      if (ctl_i.k_init) begin
        k_q <= '0;
        l_q <= '0;
      end else if (ctl_i.l_next) begin
        if (l_last) begin
          k_q <= k_q + KW'(1);
          l_q <= '0;
        end else begin
          l_q <= l_q + KW'(1);
        end
      end
      if (ctl_i.rm_init || ctl_i.i_init) i_q <= '0;
      else if (ctl_i.rm_write || ctl_i.i_next) i_q <= i_q + EA'(1);
      if (ctl_i.j_init) j_q <= '0;
      else if (ctl_i.j_next) j_q <= j_q + EA'(1);
      if (ctl_i.h_init) h_q <= '0;
      else if (ctl_i.h_next) h_q <= h_q + EA'(1);
      if (ctl_i.num_calc) begin
        lo_q <= '0;
        hi_q <= eb_eff;
      end else if (ctl_i.bs_cmp) begin
        if (bs_le) hi_q <= mid;
        else lo_q <= mid + EW'(1);
      end
    end
  end

  // Arithmetic registers
  logic [WW-1:0] w1_q, w2_q, w3_q;
  logic [DW-1:0] den_q;
  logic [NW-1:0] a1_q, a2_q, a3_q, num_q, bs_prod;
  logic [15:0]   p1v_q;
  logic [31:0]   p12_q;

  assign bs_prod = NW'(den_q) * NW'(rm_rd);
  assign bs_le   = num_q <= bs_prod;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rm_init) rmax_q <= '0;
    else if (ctl_i.rm_write) rmax_q <= rmax_new;
    if (ctl_i.w_calc) begin
      w1_q  <= WW'(bright1_q) * WW'(k_q);
      w2_q  <= WW'(bright2_q) * WW'(l_q);
      w3_q  <= WW'(bright3_q) * WW'(m_cnt);
      row_q <= RW'(tb_eff) * RW'(k_q) + RW'(l_q);
    end
    if (ctl_i.den_calc) begin
      den_q  <= DW'(w1_q) + DW'(w2_q) + DW'(w3_q);
      base_q <= HA'(PW'(row_q) * PW'(eb_eff));
    end
    if (ctl_i.i_take) begin
      p1v_q <= p1_rd;
      a1_q  <= NW'(w1_q) * NW'(eps_rd);
    end
    if (ctl_i.j_take) begin
      p12_q <= 32'(p1v_q) * 32'(p2_rd);
      a2_q  <= NW'(w2_q) * NW'(eps_rd);
    end
    if (ctl_i.h_take) begin
      a3_q  <= NW'(w3_q) * NW'(eps_rd);
      add_q <= 32'((48'(p12_q) * 48'(p3_rd)) >> 16);
    end
    if (ctl_i.num_calc) num_q <= a1_q + a2_q + a3_q;
    if (ctl_i.addr_calc) acc_addr_q <= base_q + HA'(ix);
    if (ctl_i.host_rd) rd_ok_q <= read_ok;
  end

  // Status towards the controller
  assign sts_o.clr_last = clr_addr_q == HA'(HIST_DEPTH - 1);
  assign sts_o.empty    = (tb_eff == '0) || (eb_eff == '0);
  assign sts_o.den_zero = (w1_q | w2_q | w3_q) == '0;
  assign sts_o.kl_last  = k_last && l_last;
  assign sts_o.i_last   = EW'(i_q) == eb_eff - EW'(1);
  assign sts_o.j_last   = EW'(j_q) == eb_eff - EW'(1);
  assign sts_o.h_last   = EW'(h_q) == eb_eff - EW'(1);
  assign sts_o.p1_ok    = p1_rd > thr_q;
  assign sts_o.p2_ok    = p2_rd > thr_q;
  assign sts_o.p3_ok    = p3_rd > thr_q;
  assign sts_o.bs_run   = lo_q < hi_q;

  // Result register, shown for one cycle
  logic            done_q;
  tsemh_pkg::rsp_t rsp_q;
  logic [1:0]      run_stat;
  assign run_stat = sat_q ? tsemh_pkg::STAT_SAT : tsemh_pkg::STAT_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.resp_load | ctl_i.resp_read | ctl_i.resp_cmp | ctl_i.resp_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.resp_load) begin
      rsp_q.read_data <= '0;
      rsp_q.status    <= load_ok ? tsemh_pkg::STAT_OK : tsemh_pkg::STAT_RANGE;
    end else if (ctl_i.resp_read) begin
      rsp_q.read_data <= rd_ok_q ? hist_rd : 32'd0;
      rsp_q.status    <= rd_ok_q ? run_stat : tsemh_pkg::STAT_RANGE;
    end else if (ctl_i.resp_cmp) begin
      rsp_q.read_data <= '0;
      rsp_q.status    <= run_stat;
    end else if (ctl_i.resp_bad) begin
      rsp_q.read_data <= '0;
      rsp_q.status    <= tsemh_pkg::STAT_RANGE;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### rtl/tsemh_chk.sv
// Port-level checker of the mixture histogram, bound to the top level.
// Depends on tsemh_pkg and three_state_eps_mixture_histogram.
module tsemh_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input tsemh_pkg::req_t req_i,
  input logic            done_o,
  input tsemh_pkg::rsp_t rsp_o
);

  // Loads and unknown commands answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.cmd != tsemh_pkg::CMD_COMPUTE &&
    req_i.cmd != tsemh_pkg::CMD_READ |=> done_o)
    else $error("short request gave no result");

  // Compute and read hold busy after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.cmd == tsemh_pkg::CMD_COMPUTE ||
    req_i.cmd == tsemh_pkg::CMD_READ) |=> busy && !done_o)
    else $error("long request did not hold busy");

  // A read answers after the histogram read port and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.cmd == tsemh_pkg::CMD_READ |=> ##1 done_o)
    else $error("read result missing");

  // Range-error results carry zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == tsemh_pkg::STAT_RANGE |-> rsp_o.read_data == 32'd0)
    else $error("range error with data");

endmodule

bind three_state_eps_mixture_histogram tsemh_chk u_chk (.*);
